/* rtl/dq_pkg.sv */
package dq_pkg;

    localparam int WORD_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;

    localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [ST_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic signed [WORD_W-1:0] NONE_WORD = -32'sd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_REPLY
    } dq_state_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] push_value;
    } dq_request_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        logic [ST_W-1:0]          status;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_empty;
        logic                     is_full;
    } dq_result_t;

endpackage

/* rtl/dq_ram.sv */
module dq_ram #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [IDX_W-1:0]                  wr_addr,
    input  logic signed [dq_pkg::WORD_W-1:0]  wr_data,
    input  logic [IDX_W-1:0]                  rd_addr_a,
    input  logic [IDX_W-1:0]                  rd_addr_b,
    output logic signed [dq_pkg::WORD_W-1:0]  rd_data_a,
    output logic signed [dq_pkg::WORD_W-1:0]  rd_data_b
);

    logic signed [dq_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

/* rtl/dq_ctrl.sv */
module dq_ctrl #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  dq_pkg::dq_request_t               request,
    output logic                              done,
    output dq_pkg::dq_result_t                result,
    output logic                              we,
    output logic [IDX_W-1:0]                  wr_addr,
    output logic signed [dq_pkg::WORD_W-1:0]  wr_data,
    output logic [IDX_W-1:0]                  rd_addr_a,
    output logic [IDX_W-1:0]                  rd_addr_b,
    input  logic signed [dq_pkg::WORD_W-1:0]  rd_data_a,
    input  logic signed [dq_pkg::WORD_W-1:0]  rd_data_b
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    dq_pkg::dq_state_t                state_reg, state_next;
    logic [IDX_W-1:0]                 head_reg, head_next;
    logic [IDX_W-1:0]                 tail_reg, tail_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [dq_pkg::ST_W-1:0]          status_reg, status_next;
    logic signed [dq_pkg::WORD_W-1:0] popped_reg, popped_next;
    logic signed [dq_pkg::WORD_W-1:0] front_reg, front_next;
    logic signed [dq_pkg::WORD_W-1:0] rear_reg, rear_next;
    logic [IDX_W-1:0]                 head_prev, head_succ, tail_prev, tail_succ;
    logic                             is_empty, is_full;

    assign head_prev = (head_reg == '0) ? LAST_IDX : head_reg - IDX_W'(1);
    assign head_succ = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
    assign tail_prev = (tail_reg == '0) ? LAST_IDX : tail_reg - IDX_W'(1);
    assign tail_succ = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == FULL_CNT);

    assign rd_addr_a = head_reg;
    assign rd_addr_b = tail_prev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dq_pkg::S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            front_reg <= dq_pkg::NONE_WORD;
            rear_reg  <= dq_pkg::NONE_WORD;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            front_reg <= front_next;
            rear_reg  <= rear_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        popped_reg <= popped_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = status_reg;
        popped_next = popped_reg;
        front_next  = front_reg;
        rear_next   = rear_reg;
        we          = 1'b0;
        wr_addr     = tail_reg;
        wr_data     = request.push_value;
        busy        = (state_reg != dq_pkg::S_IDLE);
        done        = 1'b0;
        result      = '0;
        case (state_reg)
            dq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next  = dq_pkg::S_READ;
                    status_next = dq_pkg::STATUS_OK;
                    popped_next = dq_pkg::NONE_WORD;
                    case (request.op)
                        dq_pkg::OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = dq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                wr_addr    = head_prev;
                                head_next  = head_prev;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        dq_pkg::OP_PUSH_REAR:
                        begin
                            if (is_full)
                            begin
                                status_next = dq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                wr_addr    = tail_reg;
                                tail_next  = tail_succ;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        dq_pkg::OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = dq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                popped_next = front_reg;
                                head_next   = head_succ;
                                count_next  = count_reg - CNT_W'(1);
                            end
                        end
                        dq_pkg::OP_POP_REAR:
                        begin
                            if (is_empty)
                            begin
                                status_next = dq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                popped_next = rear_reg;
                                tail_next   = tail_prev;
                                count_next  = count_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            dq_pkg::S_READ:
            begin
                state_next = dq_pkg::S_REPLY;
            end
            dq_pkg::S_REPLY:
            begin
                state_next          = dq_pkg::S_IDLE;
                front_next          = is_empty ? dq_pkg::NONE_WORD : rd_data_a;
                rear_next           = is_empty ? dq_pkg::NONE_WORD : rd_data_b;
                done                = 1'b1;
                result.popped_value = popped_reg;
                result.status       = status_reg;
                result.front_value  = front_next;
                result.rear_value   = rear_next;
                result.occupancy    = dq_pkg::OCC_W'(count_reg);
                result.is_empty     = is_empty;
                result.is_full      = is_full;
            end
            default:
            begin
                state_next = dq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/double_ended_queue.sv */
// Bounded double-ended queue of signed 32-bit words held in a DEPTH-entry ring
// memory. An item is taken when start is high and busy is low; it pushes at
// the front or rear, pops from the front or rear, or only queries. Each item
// runs through the S_IDLE, S_READ and S_REPLY states in turn: in S_IDLE the
// accept updates the pointers and writes the ring, in S_READ the new front and
// rear entries are read from the memory's two read ports, and S_REPLY presents
// the result with done high for exactly one cycle. The receiver cannot stall,
// so the result must be captured in the cycle done is high; busy stays high
// until then. A pop from an empty queue returns -1 with the empty status, and
// a push into a full queue is refused with the full status. The occupancy
// field carries the low five bits of the count.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dq_pkg::dq_request_t request,
    output logic                done,
    output dq_pkg::dq_result_t  result
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                             we;
    logic [IDX_W-1:0]                 wr_addr;
    logic signed [dq_pkg::WORD_W-1:0] wr_data;
    logic [IDX_W-1:0]                 rd_addr_a;
    logic [IDX_W-1:0]                 rd_addr_b;
    logic signed [dq_pkg::WORD_W-1:0] rd_data_a;
    logic signed [dq_pkg::WORD_W-1:0] rd_data_b;

    dq_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .we        (we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    dq_ram #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk       (clk),
        .we        (we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

endmodule
